// ===== design/olst_pkg.sv =====
// shared types and constants for the ordered list store
package olst_pkg;

   // field widths
   localparam int VALUE_W    = 32;
   localparam int FUNC_W     = 3;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 3;
   localparam int FOUND_W    = 5;
   localparam int COUNT_W    = 6;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // cells examined by the match scanner per cycle
   localparam int SCAN_W     = 8;
   localparam int SCAN_SEL_W = 3;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd2;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_INSERT     = 3'd4;
   localparam logic [FUNC_W-1:0] FN_ERASE      = 3'd5;
   localparam logic [FUNC_W-1:0] FN_FIND       = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } olst_state_type;

   // broadcast to every cell
   typedef struct packed {
      logic open_gap;
      logic close_gap;
      logic compare;
   } cell_cmd_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_cmd_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_status_type;

endpackage

// ===== design/olst_cell.sv =====
// one list slot: holds an element, shifts with its neighbors, flags a match
module olst_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = 6
) (
   input  logic                         clock,
   input  olst_pkg::cell_cmd_type       cmd,
   input  logic [CMP_W-1:0]             gap_at,
   input  logic [CMP_W-1:0]             count,
   input  logic [olst_pkg::VALUE_W-1:0] value,
   input  logic [olst_pkg::VALUE_W-1:0] left_data,
   input  logic [olst_pkg::VALUE_W-1:0] right_data,
   output logic [olst_pkg::VALUE_W-1:0] data,
   output logic                         hit
);
   import olst_pkg::*;

   localparam logic [CMP_W-1:0] MY_INDEX = CMP_W'(INDEX);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               hit_ff;
   logic               hit_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.open_gap) begin
         if (MY_INDEX > gap_at) begin
            data_in = left_data;
         end else if (MY_INDEX == gap_at) begin
            data_in = value;
         end
      end else if (cmd.close_gap) begin
         if (MY_INDEX >= gap_at) begin
            data_in = right_data;
         end
      end
   end

   // only occupied slots may match
   assign hit_in = cmd.compare ? ((data_ff == value) && (MY_INDEX < count)) : hit_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// ===== design/olst_scan.sv =====
// lowest-index match search over registered hit flags, a group of cells per cycle
module olst_scan #(
   parameter int CAPACITY = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  olst_pkg::scan_cmd_type       cmd,
   input  logic [CAPACITY-1:0]          hits,
   output olst_pkg::scan_status_type    status,
   output logic [olst_pkg::FOUND_W-1:0] found_index
);
   import olst_pkg::*;

   localparam int NUM_CHUNKS = (CAPACITY + SCAN_W - 1) / SCAN_W;
   localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int PAD_W      = NUM_CHUNKS * SCAN_W;

   logic [PAD_W-1:0]      hits_pad;
   logic [CHUNK_W-1:0]    chunk_ff;
   logic [CHUNK_W-1:0]    chunk_in;
   logic [SCAN_W-1:0]     chunk_hits;
   logic [SCAN_SEL_W-1:0] sel;
   logic                  last_chunk;

   assign hits_pad   = PAD_W'(hits);
   assign chunk_hits = hits_pad[chunk_ff*SCAN_W +: SCAN_W];
   assign last_chunk = (chunk_ff == CHUNK_W'(NUM_CHUNKS - 1));

   // lowest set bit of the group
   always_comb begin
      sel = '0;
      for (int k = SCAN_W - 1; k >= 0; k--) begin
         if (chunk_hits[k]) begin
            sel = SCAN_SEL_W'(k);
         end
      end
   end

   always_comb begin
      chunk_in = chunk_ff;
      if (cmd.start) begin
         chunk_in = '0;
      end else if (cmd.step) begin
         chunk_in = chunk_ff + CHUNK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= '0;
      end else begin
         chunk_ff <= chunk_in;
      end
   end

   assign status.found = |chunk_hits;
   assign status.done  = (|chunk_hits) || last_chunk;
   assign found_index  = FOUND_W'({chunk_ff, sel});

endmodule

// ===== design/ordered_list_store.sv =====
// top level of the ordered list store: cell row, match scanner and request control
//
// A bounded ordered list of up to CAPACITY signed 32-bit values kept in a row
// of register cells, one element per cell, element 0 in cell 0. Each request
// carries an operation (push back, pop back, push front, pop front, insert,
// erase, find) and returns exactly one response with a status, the index of
// the first match for a successful find (else 0) and the element count after
// the operation. Insert and push front move every later element up one cell
// and erase and pop front move them down one cell, all cells shifting in the
// same cycle, so after any operation other than find a new request can follow
// in the next cycle once the response slot is free. Find compares all cells
// at once in the accepting cycle, then the match scanner walks the registered
// hit flags eight cells per cycle and stops at the first group with a hit;
// no request is taken until the scan is done. Full, empty and bad position
// cases leave the list unchanged and are reported in the status. Reset
// empties the list.
module ordered_list_store #(
   parameter int CAPACITY = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [olst_pkg::REQ_DATA_W-1:0] req_tdata,  // func, value, position
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [olst_pkg::RSP_DATA_W-1:0] rsp_tdata   // status, found_index, count
);
   import olst_pkg::*;

   // count must hold CAPACITY itself; compares run at the wider of count and position
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request fields
   logic [FUNC_W-1:0]         req_func;
   logic signed [VALUE_W-1:0] req_value;
   logic [POS_W-1:0]          req_position;
   logic                      req_accept;

   // list state
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] count_x;
   logic [CMP_W-1:0] pos_x;
   logic             full;
   logic             empty;

   // operation decode
   cell_cmd_type         cell_cmd;
   logic [CMP_W-1:0]     gap_at;
   logic [STATUS_W-1:0]  op_status;

   // cell row
   logic [VALUE_W-1:0]   cell_data [CAPACITY];
   logic [CAPACITY-1:0]  cell_hit;

   // scanner
   scan_cmd_type         scan_cmd;
   scan_status_type      scan_status;
   logic [FOUND_W-1:0]   scan_index;

   // control and response register
   olst_state_type       state_ff;
   olst_state_type       state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [STATUS_W-1:0]  rsp_status_in;
   logic [FOUND_W-1:0]   rsp_found_ff;
   logic [FOUND_W-1:0]   rsp_found_in;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [COUNT_W-1:0]   rsp_count_in;

   assign req_func     = req_tdata[FUNC_W-1:0];
   assign req_value    = req_tdata[FUNC_W +: VALUE_W];
   assign req_position = req_tdata[FUNC_W + VALUE_W +: POS_W];

   // take a request only when idle and the response slot is empty or frees up this cycle
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign count_x = CMP_W'(count_ff);
   assign pos_x   = CMP_W'(req_position);
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);

   // decode the accepted request into a cell row command and the new count
   always_comb begin
      cell_cmd  = '0;
      gap_at    = '0;
      op_status = STATUS_OK;
      count_in  = count_ff;
      if (req_accept) begin
         unique case (req_func)
            FN_PUSH_BACK: begin
               if (full) begin
                  op_status = STATUS_FULL;
               end else begin
                  cell_cmd.open_gap = 1'b1;
                  gap_at            = count_x;
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            FN_POP_BACK: begin
               // the top cell just drops out of range
               if (empty) begin
                  op_status = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            FN_PUSH_FRONT: begin
               if (full) begin
                  op_status = STATUS_FULL;
               end else begin
                  cell_cmd.open_gap = 1'b1;
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            FN_POP_FRONT: begin
               if (empty) begin
                  op_status = STATUS_EMPTY;
               end else begin
                  cell_cmd.close_gap = 1'b1;
                  count_in           = count_ff - CNT_W'(1);
               end
            end
            FN_INSERT: begin
               // position check wins over full check
               if (pos_x > count_x) begin
                  op_status = STATUS_BAD_POS;
               end else if (full) begin
                  op_status = STATUS_FULL;
               end else begin
                  cell_cmd.open_gap = 1'b1;
                  gap_at            = pos_x;
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            FN_ERASE: begin
               if (empty) begin
                  op_status = STATUS_EMPTY;
               end else if (pos_x >= count_x) begin
                  op_status = STATUS_BAD_POS;
               end else begin
                  cell_cmd.close_gap = 1'b1;
                  gap_at             = pos_x;
                  count_in           = count_ff - CNT_W'(1);
               end
            end
            FN_FIND: begin
               cell_cmd.compare = 1'b1;
            end
            default: begin
               // unused code: no operation, status ok
            end
         endcase
      end
   end

   // row of cells, each fed by its neighbors, with zero in place of a missing neighbor at the ends
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_data;
      logic [VALUE_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      olst_cell #(
         .INDEX (i),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .gap_at     (gap_at),
         .count      (count_x),
         .value      (req_value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );
   end

   olst_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .cmd         (scan_cmd),
      .hits        (cell_hit),
      .status      (scan_status),
      .found_index (scan_index)
   );

   // sequencing and response register
   always_comb begin
      state_in      = state_ff;
      scan_cmd      = '0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_func == FN_FIND) begin
                  // hit flags are captured by the cells at this edge
                  scan_cmd.start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = op_status;
                  rsp_found_in  = '0;
                  rsp_count_in  = COUNT_W'(count_in);
               end
            end
         end
         ST_SCAN: begin
            // response slot is known empty here
            if (scan_status.done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = scan_status.found ? STATUS_OK : STATUS_NOT_FOUND;
               rsp_found_in  = scan_status.found ? scan_index : '0;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end else begin
               scan_cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_found_ff, rsp_status_ff});

   // list never grows past its capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // no request taken while a find is being scanned
   a_scan_blocks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_tready)
      else $error("request accepted during find scan");

   // count stays put through a find scan
   a_scan_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> (count_ff == $past(count_ff)))
      else $error("count changed during find scan");

   // operations other than find respond in the next cycle
   a_plain_response : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func != FN_FIND)) |=> rsp_valid_ff)
      else $error("missing response after single-cycle request");

   // a finished scan yields a find response
   a_find_response : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && scan_status.done) |=>
         (rsp_valid_ff && ((rsp_status_ff == STATUS_OK) ||
                           (rsp_status_ff == STATUS_NOT_FOUND))))
      else $error("bad find response");

endmodule
